FILE: rtl/dcgr_pkg.sv
// Shared types and constants for the dual-chip graphic LCD refresh engine.
package dcgr_pkg;

   localparam int PAGES        = 8;
   localparam int COLUMNS      = 128;
   localparam int CMD_STEPS    = 4;
   localparam int HALF_COLUMNS = 64;
   localparam int STORE_DEPTH  = 1024;
   localparam int ADDR_W       = 10;
   localparam int PAGE_W       = 3;
   localparam int COL_W        = 7;
   localparam int STEP_W       = 8;

   localparam logic [7:0]        CMD_START_LINE = 8'h40;
   localparam logic [7:0]        CMD_SET_PAGE   = 8'hB8;
   localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(CMD_STEPS + COLUMNS - 1);
   localparam logic [PAGE_W-1:0] PAGE_LAST      = PAGE_W'(PAGES - 1);
   localparam logic [STEP_W-1:0] STEP_DATA0     = STEP_W'(CMD_STEPS);
   localparam logic [COL_W-1:0]  COL_HALF       = COL_W'(HALF_COLUMNS);

   typedef enum logic [1:0] {
      KIND_STORE = 2'd0,
      KIND_START = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_IDLE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PIN_HOLD  = 2'd0,
      PIN_SETUP = 2'd1,
      PIN_FALL  = 2'd2
   } pin_action_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] address;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic        enable_pin;
      logic        data_select_pin;
      logic        chip_select_pin;
      logic        read_write_pin;
      logic [7:0]  bus_byte;
      logic [15:0] port_d_pattern;
      logic [15:0] port_e_pattern;
      logic        busy_res;
      logic        frame_done;
      logic        write_refused;
   } rsp_type;

   // stage-one decision handed to the pin stage
   typedef struct packed {
      pin_action_type action;
      logic           is_data;
      logic           chip_sel;
      logic [7:0]     cmd_byte;
      logic           busy;
      logic           done;
      logic           refused;
   } op_type;

endpackage

FILE: rtl/dcgr_sequencer.sv
// Refresh sequencer: frame store, page/step counters and strobe phase.
module dcgr_sequencer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dcgr_pkg::req_type req_data,
   input  logic             advance,
   output logic             op_valid,
   output dcgr_pkg::op_type op,
   output logic [7:0]       rd_data
);
   import dcgr_pkg::*;

   logic [7:0] mem [STORE_DEPTH];

   logic              running_ff, running_in;
   logic              phase_ff, phase_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              op_valid_ff, op_valid_in;
   op_type            op_ff, op_in;
   logic [7:0]        rd_ff;

   logic              accept;
   logic              wr_en;
   logic [COL_W-1:0]  col;
   logic [ADDR_W-1:0] rd_addr;
   kind_type          kind;

   assign req_stall = op_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign kind      = kind_type'(req_data.kind);
   assign col       = step_ff[COL_W-1:0] - STEP_DATA0[COL_W-1:0];
   assign rd_addr   = {page_ff, col};

   always_comb begin
      running_in  = running_ff;
      phase_in    = phase_ff;
      page_in     = page_ff;
      step_in     = step_ff;
      wr_en       = 1'b0;
      op_in       = '0;
      op_in.action = PIN_HOLD;
      unique case (kind)
         KIND_STORE: begin
            if (running_ff) begin
               op_in.refused = 1'b1;
            end else begin
               wr_en = 1'b1;
            end
         end
         KIND_START: begin
            if (!running_ff) begin
               running_in = 1'b1;
               phase_in   = 1'b0;
               page_in    = '0;
               step_in    = '0;
            end
         end
         KIND_TICK: begin
            if (running_ff) begin
               if (!phase_ff) begin
                  phase_in     = 1'b1;
                  op_in.action = PIN_SETUP;
                  if (step_ff < STEP_DATA0) begin
                     op_in.is_data  = 1'b0;
                     op_in.chip_sel = step_ff[1];
                     op_in.cmd_byte = step_ff[0] ? (CMD_SET_PAGE | {5'd0, page_ff})
                                                 : CMD_START_LINE;
                  end else begin
                     op_in.is_data  = 1'b1;
                     op_in.chip_sel = (col < COL_HALF);
                  end
               end else begin
                  phase_in     = 1'b0;
                  op_in.action = PIN_FALL;
                  if (step_ff >= STEP_LAST) begin
                     step_in = '0;
                     if (page_ff >= PAGE_LAST) begin
                        page_in    = '0;
                        running_in = 1'b0;
                        op_in.done = 1'b1;
                     end else begin
                        page_in = page_ff + 1'b1;
                     end
                  end else begin
                     step_in = step_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      op_in.busy = running_in;
   end

   always_comb begin
      if (accept) begin
         op_valid_in = 1'b1;
      end else if (advance) begin
         op_valid_in = 1'b0;
      end else begin
         op_valid_in = op_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         phase_ff    <= 1'b0;
         page_ff     <= '0;
         step_ff     <= '0;
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= op_valid_in;
         if (accept) begin
            running_ff <= running_in;
            phase_ff   <= phase_in;
            page_ff    <= page_in;
            step_ff    <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_in;
         rd_ff <= mem[rd_addr];
         if (wr_en) begin
            mem[req_data.address] <= req_data.value;
         end
      end
   end

   assign op_valid = op_valid_ff;
   assign op       = op_ff;
   assign rd_data  = rd_ff;

endmodule

FILE: rtl/dual_chip_glcd_refresh_engine.sv
// Top level of the dual-chip graphic LCD refresh engine.
// Usage:
//   req_ channel carries one transaction per item: store a frame byte, start a
//   refresh, one strobe tick or an idle item. Every request transaction yields
//   exactly one rsp_ transaction holding the display pin levels after that item
//   plus busy, frame-done and write-refused flags.
//   A request is registered in the sequencer stage on accept and then in the
//   response stage; a new request is taken every cycle while req_stall is low,
//   so throughput is one item per cycle. The frame store read port registers
//   the byte read on accept; the response stage places it on the pins.
//   A refresh of the full frame takes 2 ticks per byte, 132 bytes per page,
//   8 pages. Store requests during a refresh are refused and flagged.
//   Reset clears the counters, the pins and both pipeline valids; the frame
//   store keeps its contents and must be written before it is refreshed.
//   When rsp_stall is high the response holds and req_stall rises as soon
//   as the internal stage is full; no transaction is dropped.
module dual_chip_glcd_refresh_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dcgr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dcgr_pkg::rsp_type rsp_data
);
   import dcgr_pkg::*;

   logic       advance;
   logic       op_valid;
   op_type     op;
   logic [7:0] rd_data;

   logic       load;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [7:0] bus_ff, bus_in;
   logic       en_ff, en_in;
   logic       ds_ff, ds_in;
   logic       cs_ff, cs_in;

   dcgr_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .op_valid  (op_valid),
      .op        (op),
      .rd_data   (rd_data)
   );

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign load    = op_valid && advance;

   always_comb begin
      bus_in = bus_ff;
      en_in  = en_ff;
      ds_in  = ds_ff;
      cs_in  = cs_ff;
      unique case (op.action)
         PIN_SETUP: begin
            bus_in = op.is_data ? rd_data : op.cmd_byte;
            en_in  = 1'b1;
            ds_in  = op.is_data;
            cs_in  = op.chip_sel;
         end
         PIN_FALL: begin
            en_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in.enable_pin      = en_in;
      rsp_in.data_select_pin = ds_in;
      rsp_in.chip_select_pin = cs_in;
      rsp_in.read_write_pin  = 1'b0;
      rsp_in.bus_byte        = bus_in;
      rsp_in.port_d_pattern  = {bus_in[1:0], 12'd0, bus_in[3:2]};
      rsp_in.port_e_pattern  = {5'd0, bus_in[7:4], 7'd0};
      rsp_in.busy_res        = op.busy;
      rsp_in.frame_done      = op.done;
      rsp_in.write_refused   = op.refused;
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         bus_ff       <= '0;
         en_ff        <= 1'b0;
         ds_ff        <= 1'b0;
         cs_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            bus_ff <= bus_in;
            en_ff  <= en_in;
            ds_ff  <= ds_in;
            cs_ff  <= cs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: dv/dual_chip_glcd_refresh_engine_test.sv
// Self-checking testbench for the dual-chip graphic LCD refresh engine.
module dual_chip_glcd_refresh_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dcgr_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PRESSURE_HOLD = 300;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   dual_chip_glcd_refresh_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // display image: frame store, sequencer and pin levels
   logic [7:0] frame_img [0:STORE_DEPTH-1];
   logic       disp_busy  = 1'b0;
   logic       disp_phase = 1'b0;
   logic [2:0] disp_page  = '0;
   logic [7:0] disp_step  = '0;
   logic       pin_en     = 1'b0;
   logic       pin_ds     = 1'b0;
   logic       pin_cs     = 1'b0;
   logic [7:0] pin_bus    = '0;

   rsp_type pending_pins [$];
   int      error_count   = 0;
   int      cycle_count   = 0;
   int      stall_left    = 0;
   bit      gaps_on       = 1'b0;
   bit      stalls_on     = 1'b0;
   bit      pressure_req  = 1'b0;
   bit      pressure_seen = 1'b0;

   function automatic rsp_type step_display(input req_type item);
      rsp_type    r;
      logic       done;
      logic       refused;
      logic [7:0] col;
      done    = 1'b0;
      refused = 1'b0;
      case (kind_type'(item.kind))
         KIND_STORE: begin
            if (disp_busy)
               refused = 1'b1;
            else
               frame_img[item.address] = item.value;
         end
         KIND_START: begin
            if (!disp_busy) begin
               disp_busy  = 1'b1;
               disp_phase = 1'b0;
               disp_page  = '0;
               disp_step  = '0;
            end
         end
         KIND_TICK: begin
            if (disp_busy && !disp_phase) begin
               if (disp_step < STEP_DATA0) begin
                  pin_bus = disp_step[0] ? (CMD_SET_PAGE | {5'd0, disp_page}) : CMD_START_LINE;
                  pin_ds  = 1'b0;
                  pin_cs  = disp_step[1];
               end else begin
                  col     = disp_step - STEP_DATA0;
                  pin_bus = frame_img[{disp_page, col[6:0]}];
                  pin_ds  = 1'b1;
                  pin_cs  = (col < HALF_COLUMNS);
               end
               pin_en     = 1'b1;
               disp_phase = 1'b1;
            end else if (disp_busy) begin
               pin_en     = 1'b0;
               disp_phase = 1'b0;
               if (disp_step == STEP_LAST) begin
                  disp_step = '0;
                  if (disp_page == PAGE_LAST) begin
                     disp_page = '0;
                     disp_busy = 1'b0;
                     done      = 1'b1;
                  end else begin
                     disp_page = disp_page + 3'd1;
                  end
               end else begin
                  disp_step = disp_step + 8'd1;
               end
            end
         end
         default: ;
      endcase
      r.enable_pin      = pin_en;
      r.data_select_pin = pin_ds;
      r.chip_select_pin = pin_cs;
      r.read_write_pin  = 1'b0;
      r.bus_byte        = pin_bus;
      r.port_d_pattern  = {pin_bus[1:0], 12'd0, pin_bus[3:2]};
      r.port_e_pattern  = {5'd0, pin_bus[7:4], 7'd0};
      r.busy_res        = disp_busy;
      r.frame_done      = done;
      r.write_refused   = refused;
      return r;
   endfunction

   task automatic check_pins(input rsp_type got);
      rsp_type want;
      if (pending_pins.size() == 0) begin
         error_count++;
         $display("%0t: unexpected transaction, expected none actual %0h", $time, got);
      end else begin
         want = pending_pins.pop_front();
         if (got !== want) begin
            error_count++;
            $display("%0t: response mismatch, expected %0h actual %0h", $time, want, got);
         end
      end
   endtask

   // receiver: checks accepted transactions and drives stall
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_pins(rsp_data);
         if (pressure_req && !pressure_seen) begin
            pressure_seen = 1'b1;
            stall_left    = PRESSURE_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stalls_on && $urandom_range(9) == 0) begin
            stall_left = $urandom_range(17, 1) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(input kind_type kind, input logic [9:0] address,
                            input logic [7:0] value);
      req_type item;
      item.kind    = kind;
      item.address = address;
      item.value   = value;
      if (gaps_on && $urandom_range(7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(17, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pins.push_back(step_display(item));
   endtask

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(99);
      if (disp_busy) begin
         if (pick < 85)
            send_item(KIND_TICK, 10'($urandom), 8'($urandom));
         else if (pick < 90)
            send_item(KIND_STORE, 10'($urandom), 8'($urandom));
         else if (pick < 95)
            send_item(KIND_START, 10'($urandom), 8'($urandom));
         else
            send_item(KIND_IDLE, 10'($urandom), 8'($urandom));
      end else begin
         if (pick < 60)
            send_item(KIND_STORE, 10'($urandom), 8'($urandom));
         else if (pick < 75)
            send_item(KIND_START, 10'($urandom), 8'($urandom));
         else if (pick < 90)
            send_item(KIND_TICK, 10'($urandom), 8'($urandom));
         else
            send_item(KIND_IDLE, 10'($urandom), 8'($urandom));
      end
   endtask

   // ticks until the frame ends, with occasional ignored or refused transactions
   task automatic run_to_frame_end();
      int pick;
      while (disp_busy) begin
         pick = $urandom_range(39);
         if (pick == 0)
            send_item(KIND_START, 10'($urandom), 8'($urandom));
         else if (pick == 1)
            send_item(KIND_STORE, 10'($urandom), 8'($urandom));
         else if (pick == 2)
            send_item(KIND_IDLE, 10'($urandom), 8'($urandom));
         else
            send_item(KIND_TICK, 10'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_idle_items();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_item(KIND_TICK, 10'h3FF, 8'hFF);
      send_item(KIND_IDLE, 10'h000, 8'h00);
      send_item(KIND_IDLE, 10'h3FF, 8'hFF);
      send_item(KIND_TICK, 10'h000, 8'h00);
   endtask

   task automatic test_store_extremes();
      send_item(KIND_STORE, 10'h000, 8'h00);
      send_item(KIND_STORE, 10'h3FF, 8'hFF);
      send_item(KIND_STORE, 10'h2AA, 8'h55);
      send_item(KIND_STORE, 10'h155, 8'hAA);
      send_item(KIND_STORE, 10'h03F, 8'h0F);
      send_item(KIND_STORE, 10'h040, 8'hF0);
   endtask

   // every entry is written before any refresh reads the store
   task automatic test_fill_store();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      for (int a = 0; a < STORE_DEPTH; a++) begin
         if (a == STORE_DEPTH / 2) begin
            gaps_on   = 1'b1;
            stalls_on = 1'b1;
         end
         if ($urandom_range(31) == 0)
            send_item(($urandom_range(1) != 0) ? KIND_TICK : KIND_IDLE,
                      10'($urandom), 8'($urandom));
         send_item(KIND_STORE, a[9:0], 8'($urandom));
      end
   endtask

   task automatic test_refresh_specials();
      send_item(KIND_START, 10'($urandom), 8'($urandom));
      send_item(KIND_START, 10'($urandom), 8'($urandom));
      send_item(KIND_STORE, 10'($urandom), 8'($urandom));
      repeat (5) send_item(KIND_TICK, 10'($urandom), 8'($urandom));
      send_item(KIND_IDLE, 10'($urandom), 8'($urandom));
      repeat (4) send_item(KIND_TICK, 10'($urandom), 8'($urandom));
      run_to_frame_end();
      send_item(KIND_TICK, 10'($urandom), 8'($urandom));
      send_item(KIND_STORE, 10'h3FF, 8'hFF);
   endtask

   task automatic test_random_refresh();
      repeat ($urandom_range(40, 5)) begin
         if ($urandom_range(9) == 0)
            send_item(KIND_IDLE, 10'($urandom), 8'($urandom));
         else
            send_item(KIND_STORE, 10'($urandom), 8'($urandom));
      end
      send_item(KIND_START, 10'($urandom), 8'($urandom));
      run_to_frame_end();
   endtask

   task automatic test_back_pressure();
      pressure_req = 1'b1;
      repeat (60) send_random_item();
   endtask

   task automatic test_random_mix();
      for (int n = 0; n < 550; n++) begin
         if (n == 450) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         send_random_item();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_items();
      test_store_extremes();
      test_fill_store();
      test_refresh_specials();
      test_random_refresh();
      test_back_pressure();
      test_random_mix();
      req_valid <= 1'b0;
      while (pending_pins.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: dual_chip_glcd_refresh_engine.f
rtl/dcgr_pkg.sv
rtl/dcgr_sequencer.sv
rtl/dual_chip_glcd_refresh_engine.sv
dv/dual_chip_glcd_refresh_engine_test.sv
